// ===== rtl/set_assoc_cache_tag_replacement_top_macros.svh =====
// assertion macros for the cache tag and replacement block
`ifndef SET_ASSOC_CACHE_TAG_REPLACEMENT_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_REPLACEMENT_TOP_MACROS_SVH
// implication checked every clock outside reset
`define SACR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SACR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/sacr_pkg.sv =====
// shared types and constants for the cache tag and replacement block
package sacr_pkg;
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_LFU  = 2'd2;
    localparam logic [1:0] POL_MRU  = 2'd3;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_REPL  = 2'd2;
    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_LINES  = 2'd2;
    localparam logic [1:0] CFG_WAYS   = 2'd3;
    localparam int TAG_W = 30;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int WAY_OUT_W = 10;
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] age;
        logic [CNT_W-1:0] use_cnt;
    } t_line;
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction
endpackage

// ===== rtl/set_assoc_cache_tag_replacement_top.sv =====
// top level: line store, way walk and victim choice of the cache tag block
//
//  channel | signals                                  | dir
//  req     | i_req_valid/o_req_ready, type, address   | in
//  rsp     | o_rsp_valid/i_rsp_ready, outcome, way, wb| out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_wdata       | in
//
// an access reads one line per way through the line memory read port,
// then writes one line per way for aging and the update.
// after reset a clearing pass over every line runs before the first beat.
// a result waits in an output register; the next beat is taken and walked while
// it waits, and that walk holds in its last state until the register drains.
module set_assoc_cache_tag_replacement_top
    import sacr_pkg::*;
#(
    parameter int NUM_LINES = 1024,
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_address,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [1:0]  o_outcome,
    output logic [9:0]  o_way_used,
    output logic        o_writeback,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_wdata
);
`include "set_assoc_cache_tag_replacement_top_macros.svh"
    localparam int LW = $clog2(NUM_LINES);
    localparam int LLW = $clog2(LW + 2);
    localparam int CW = LW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    t_line            r_mem [NUM_LINES];
    logic [LW-1:0]    r_fifo [NUM_LINES];
    t_line            r_rd;
    logic [LW-1:0]    r_fifo_rd;

    logic [1:0] r_pol;
    logic [2:0] r_ob;
    logic [3:0] r_ll;
    logic [3:0] r_wl;

    logic [2:0]     r_st, n_st;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_rd_v;
    logic [LW-1:0]  r_rd_w;
    logic           r_wr;
    logic [TAG_W-1:0] r_tag;
    logic [LW-1:0]  r_base;
    logic [LW-1:0]  r_set;
    logic [LW-1:0]  r_ways_m1;
    logic           r_hit, r_empty;
    logic [LW-1:0]  r_hit_w, r_empty_w, r_best_w, r_used;
    logic [CNT_W-1:0] r_best_age, r_best_use;
    logic           r_wb;
    logic [1:0]     r_out;
    logic           r_ov;
    logic [1:0]     r_o_out;
    logic [LW-1:0]  r_o_way;
    logic           r_o_wb;

    // geometry
    logic [LLW-1:0] ll_eff, wl_eff, sl_eff;
    logic [2:0]     ob_eff;
    logic [31:0]    addr_m, blk;
    always_comb begin
        ob_eff = (r_ob < 3'd2) ? 3'd2 : r_ob;
        ll_eff = (LLW'(r_ll) > LLW'(LW)) ? LLW'(LW) : LLW'(r_ll);
        wl_eff = (LLW'(r_wl) > ll_eff) ? ll_eff : LLW'(r_wl);
        sl_eff = ll_eff - wl_eff;
        addr_m = (ADDR_BITS >= 32) ? i_address
                 : (i_address & ((32'd1 << ADDR_BITS) - 32'd1));
        blk    = addr_m >> ob_eff;
    end

    logic accept;
    assign o_req_ready = (r_st == S_IDLE);
    assign accept = i_req_valid && o_req_ready;

    // walk pointer selection
    logic [LW-1:0] rd_addr, wr_addr;
    logic          mem_we;
    t_line         wr_line;
    logic [LW-1:0] cw;
    assign cw = r_cnt[LW-1:0];

    always_comb begin
        wr_addr = r_base | cw;
        rd_addr = r_base | cw;
        mem_we  = 1'b0;
        wr_line = r_rd;
        if (r_st == S_CLEAR) begin
            mem_we  = 1'b1;
            wr_addr = cw;
            wr_line = '0;
        end else if (r_st == S_WRITE && r_rd_v) begin
            mem_we  = 1'b1;
            wr_addr = r_base | r_rd_w;
            wr_line = r_rd;
            if (r_rd_w == r_used) begin
                wr_line.age = '0;
                if (r_out == OUT_HIT) begin
                    wr_line.dirty = r_rd.dirty | r_wr;
                    if (r_pol == POL_LFU) wr_line.use_cnt = sat_inc(r_rd.use_cnt);
                end else begin
                    wr_line.valid   = 1'b1;
                    wr_line.tag     = r_tag;
                    wr_line.dirty   = r_wr;
                    wr_line.use_cnt = CNT_W'(1);
                end
                if (r_pol == POL_LFU || r_pol == POL_MRU) wr_line.age = CNT_W'(1);
            end else if (r_pol != POL_FIFO) begin
                wr_line.age = sat_inc(r_rd.age);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= wr_line;
        r_rd <= r_mem[rd_addr];
        if (r_st == S_CLEAR) r_fifo[cw] <= '0;
        else if (r_st == S_WRITE && r_cnt == CW'(0) && !r_hit && !r_empty
                 && r_pol == POL_FIFO)
            r_fifo[r_set] <= (r_fifo_rd & r_ways_m1) + LW'(1) & r_ways_m1;
        r_fifo_rd <= r_fifo[r_set];
    end

    // victim compare of the way just read against the best so far
    logic better;
    always_comb begin
        better = 1'b0;
        case (r_pol)
            POL_LRU: better = r_rd.age > r_best_age;
            POL_MRU: better = r_rd.age < r_best_age;
            POL_LFU: better = (r_rd.use_cnt < r_best_use) ||
                              (r_rd.use_cnt == r_best_use && r_rd.age > r_best_age);
            default: better = 1'b0;
        endcase
    end

    logic [LW-1:0] fifo_w;
    assign fifo_w = r_fifo_rd & r_ways_m1;

    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            S_CLEAR: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_LINES - 1)) begin
                    n_st  = S_IDLE;
                    n_cnt = '0;
                end
            end
            S_IDLE: if (accept) begin
                n_st  = S_READ;
                n_cnt = '0;
            end
            S_READ: begin
                n_cnt = r_cnt + CW'(1);
                if (cw == r_ways_m1 || r_cnt[LW]) n_st = S_DEC;
            end
            S_DEC: begin
                n_st  = S_WRITE;
                n_cnt = '0;
            end
            S_WRITE: begin
                n_cnt = r_cnt + CW'(1);
                if (r_rd_v && r_rd_w == r_ways_m1) n_st = S_DONE;
            end
            S_DONE: if (!r_ov || i_rsp_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLEAR;
            r_cnt <= '0;
            r_rd_v <= 1'b0;
            r_ov  <= 1'b0;
            r_pol <= POL_FIFO;
            r_ob  <= 3'd5;
            r_ll  <= 4'd10;
            r_wl  <= 4'd0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_rd_v <= (r_st == S_READ && n_st == S_READ) || r_st == S_READ
                      || (r_st == S_WRITE && n_st == S_WRITE);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY: r_pol <= i_cfg_wdata[1:0];
                    CFG_OFFSET: r_ob  <= i_cfg_wdata[2:0];
                    CFG_LINES:  r_ll  <= i_cfg_wdata;
                    CFG_WAYS:   r_wl  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_st == S_DONE && n_st == S_IDLE) r_ov <= 1'b1;
            else if (i_rsp_ready) r_ov <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_w <= cw;
        if (accept) begin
            r_wr      <= (i_req_type == REQ_WRITE);
            r_tag     <= TAG_W'(blk >> sl_eff);
            r_set     <= LW'(blk) & ((LW'(1) << sl_eff) - LW'(1));
            r_base    <= (LW'(blk) & ((LW'(1) << sl_eff) - LW'(1))) << wl_eff;
            r_ways_m1 <= (LW'(1) << wl_eff) - LW'(1);
            r_hit     <= 1'b0;
            r_empty   <= 1'b0;
        end
        if (r_st == S_READ && r_rd_v || r_st == S_DEC) begin
            if (!r_hit) begin
                if (r_rd.valid && r_rd.tag == r_tag) begin
                    r_hit <= 1'b1;
                    r_hit_w <= r_rd_w;
                end else if (!r_rd.valid && !r_empty) begin
                    r_empty <= 1'b1;
                    r_empty_w <= r_rd_w;
                end
            end
            if (r_rd_w == '0 || better) begin
                r_best_w <= r_rd_w;
                r_best_age <= r_rd.age;
                r_best_use <= r_rd.use_cnt;
            end
        end
        if (r_st == S_WRITE && r_cnt == CW'(0)) begin
            r_wb <= 1'b0;
            if (r_hit) begin
                r_out <= OUT_HIT;  r_used <= r_hit_w;
            end else if (r_empty) begin
                r_out <= OUT_FILL; r_used <= r_empty_w;
            end else begin
                r_out <= OUT_REPL;
                r_used <= (r_pol == POL_FIFO) ? fifo_w : r_best_w;
            end
        end
        if (r_st == S_WRITE && r_rd_v && r_rd_w == r_used && r_out == OUT_REPL)
            r_wb <= r_rd.dirty;
        if (r_st == S_DONE && n_st == S_IDLE) begin
            r_o_out <= r_out;
            r_o_way <= r_used;
            r_o_wb  <= r_wb;
        end
    end

    assign o_rsp_valid = r_ov;
    assign o_outcome   = r_o_out;
    assign o_way_used  = WAY_OUT_W'(r_o_way);
    assign o_writeback = r_o_wb;

    `SACR_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_st != S_IDLE, !o_req_ready)
    `SACR_ASSERT_IMP(a_wb_only_repl, i_clk, i_rst_n, o_rsp_valid && o_writeback,
        o_outcome == OUT_REPL)
    `SACR_ASSERT_NXT(a_done_shows, i_clk, i_rst_n, r_st == S_DONE, o_rsp_valid)
endmodule
